FILE: hdl/cpd_pkg.sv
`default_nettype none

package cpd_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_LIMIT        = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_SLACK     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_COUNT_NEEDED = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_VEL_COUNT_NEEDED   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SAFETY_COUNT_NEEDED = 3'd4;

	// register reset values
	localparam logic signed [31:0] ACCEL_LIMIT_RST = -32'sd589824;
	localparam logic [30:0] VELOCITY_SLACK_RST     = 31'd0;
	localparam logic [15:0] ACCEL_NEEDED_RST       = 16'd10;
	localparam logic [15:0] VEL_NEEDED_RST         = 16'd10;
	localparam logic [15:0] SAFETY_NEEDED_RST      = 16'd5;

	// input word
	typedef struct packed {
		logic signed [31:0] accel_vertical;
		logic signed [31:0] velocity_vertical;
	} sample_t;

	// output word
	typedef struct packed {
		logic        coasting;
		logic        velocity_falling;
		logic [15:0] accel_count;
		logic [15:0] velocity_count;
		logic [15:0] safety_count;
	} report_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

FILE: hdl/cpd_chan_if.sv
`default_nettype none

interface cpd_chan_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/cpd_history.sv
`default_nettype none

module cpd_history #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [31:0]       wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic [31:0]            rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	// write newest velocity
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/coast_phase_detector_unit.sv
// Coast phase detector. Each input word carries one vertical acceleration and
// one vertical velocity sample (signed Q16.16); each one yields exactly one
// output word with the coasting flag, the falling-velocity flag and the three
// counters after the step. The velocity history sits in a single-port-read
// memory, and one compare unit walks it one entry at a time (address, then
// compare), stopping at the first excessive rise. With n >= 4 valid history
// entries held, the walk compares up to n/2 - 1 older entries; while fewer
// than four are held, no walk runs. The input is not ready during that walk.
// A finished word waits in an output register, so the next sample is taken
// while the previous result is still pending. No clearing pass runs after
// reset: only history entries that were written are read. Write
// configuration only while no sample is in flight.
`default_nettype none

module coast_phase_detector_unit
	import cpd_pkg::*;
#(
	parameter int HISTORY_DEPTH = 16,
	parameter int COUNTER_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	cpd_chan_if.sink                    sample,
	cpd_chan_if.source                  report
);

	localparam int AW   = $clog2(HISTORY_DEPTH);
	localparam int VW   = $clog2(HISTORY_DEPTH + 1);
	localparam int CW   = COUNTER_WIDTH;
	localparam int CMPW = (CW > 16) ? CW : 16;

	localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
	localparam logic [VW-1:0] DEPTH_V   = VW'(HISTORY_DEPTH);
	localparam logic [CW-1:0] CNT_MAX   = '1;
	localparam logic [CW-1:0] CNT_ONE   = CW'(1);
	localparam logic [CW-1:0] CNT_TWO   = CW'(2);

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
		return (c == CNT_MAX) ? c : c + CNT_ONE;
	endfunction

	function automatic logic [CW-1:0] dec_floor(input logic [CW-1:0] c,
						    input logic [CW-1:0] by);
		return (c > by) ? c - by : '0;
	endfunction

	function automatic logic reached(input logic [CW-1:0] c, input logic [15:0] need);
		return CMPW'(c) >= CMPW'(need);
	endfunction

	function automatic logic [15:0] low16(input logic [CW-1:0] c);
		logic [CMPW-1:0] ext;
		ext = CMPW'(c);
		return ext[15:0];
	endfunction

	function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
		return (a == '0) ? LAST_ADDR : a - AW'(1);
	endfunction

	function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
		return (a == LAST_ADDR) ? '0 : a + AW'(1);
	endfunction

	// configuration registers
	logic signed [31:0] accel_limit_q;
	logic [30:0]        velocity_slack_q;
	logic [15:0]        accel_needed_q;
	logic [15:0]        vel_needed_q;
	logic [15:0]        safety_needed_q;

	// sequencer and state
	state_t             state_q, state_d;
	logic [AW-1:0]      head_q;
	logic [AW-1:0]      addr_q;
	logic [VW-1:0]      fill_q;
	logic [VW-1:0]      half_q;
	logic [VW-1:0]      step_q;
	logic [CW-1:0]      accel_cnt_q;
	logic [CW-1:0]      vel_cnt_q;
	logic [CW-1:0]      safety_cnt_q;
	logic signed [31:0] newer_q;
	logic               falling_q;
	logic               out_valid_q;
	report_t            out_data_q;

	// control from the sequencer
	logic               accept;
	logic               walk_start;
	logic               rd_en;
	logic               cmp_rise;
	logic               walk_last;
	logic               finish;
	logic               slot_free;

	// datapath
	logic [VW-1:0]      fill_next;
	logic [VW-1:0]      half_next;
	logic [VW-1:0]      step_next;
	logic [31:0]        rd_data;
	logic [33:0]        older_plus;
	logic [CW-1:0]      vel_cnt_next;
	logic [CW-1:0]      safety_cnt_next;
	logic               safety_cond;
	logic               coast_next;

	cpd_history #(
		.DEPTH (HISTORY_DEPTH),
		.ADDR_W(AW)
	) u_history (
		.clk  (clk),
		.we   (accept),
		.waddr(head_q),
		.wdata(sample.data.velocity_vertical),
		.re   (rd_en),
		.raddr(addr_q),
		.rdata(rd_data)
	);

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_limit_q    <= ACCEL_LIMIT_RST;
			velocity_slack_q <= VELOCITY_SLACK_RST;
			accel_needed_q   <= ACCEL_NEEDED_RST;
			vel_needed_q     <= VEL_NEEDED_RST;
			safety_needed_q  <= SAFETY_NEEDED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACCEL_LIMIT:         accel_limit_q    <= $signed(cfg_data);
				REG_VELOCITY_SLACK:      velocity_slack_q <= cfg_data[30:0];
				REG_ACCEL_COUNT_NEEDED:  accel_needed_q   <= cfg_data[15:0];
				REG_VEL_COUNT_NEEDED:    vel_needed_q     <= cfg_data[15:0];
				REG_SAFETY_COUNT_NEEDED: safety_needed_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// shared compare: newer sample against older plus slack
	assign older_plus = {{2{rd_data[31]}}, rd_data} + {3'b000, velocity_slack_q};
	assign cmp_rise   = $signed({{2{newer_q[31]}}, newer_q}) > $signed(older_plus);

	assign fill_next  = (fill_q == DEPTH_V) ? fill_q : fill_q + VW'(1);
	assign half_next  = fill_next >> 1;
	assign step_next  = step_q + VW'(1);
	assign walk_last  = step_next >= half_q;
	assign slot_free  = !out_valid_q || report.ready;

	// counter updates at the end of the walk
	always_comb begin
		vel_cnt_next = falling_q ? sat_inc(vel_cnt_q) : dec_floor(vel_cnt_q, CNT_ONE);
		safety_cond  = reached(accel_cnt_q, accel_needed_q) ||
			       reached(vel_cnt_next, vel_needed_q);
		safety_cnt_next = safety_cond ? sat_inc(safety_cnt_q)
					      : dec_floor(safety_cnt_q, CNT_ONE);
		coast_next   = safety_cond && reached(safety_cnt_next, safety_needed_q);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer outputs
	always_comb begin
		state_d      = state_q;
		accept       = 1'b0;
		walk_start   = 1'b0;
		rd_en        = 1'b0;
		finish       = 1'b0;
		sample.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid) begin
					accept     = 1'b1;
					walk_start = half_next > VW'(1);
					state_d    = walk_start ? ST_READ : ST_FINISH;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = (cmp_rise || walk_last) ? ST_FINISH : ST_READ;
			end
			ST_FINISH: begin
				if (slot_free) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// history pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			fill_q       <= '0;
			accel_cnt_q  <= '0;
			vel_cnt_q    <= '0;
			safety_cnt_q <= '0;
		end else begin
			if (accept) begin
				head_q <= addr_inc(head_q);
				fill_q <= fill_next;
				if (sample.data.accel_vertical <= accel_limit_q) begin
					accel_cnt_q <= sat_inc(accel_cnt_q);
				end else begin
					accel_cnt_q <= dec_floor(accel_cnt_q, CNT_TWO);
				end
			end
			if (finish) begin
				vel_cnt_q    <= vel_cnt_next;
				safety_cnt_q <= safety_cnt_next;
			end
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			newer_q   <= sample.data.velocity_vertical;
			addr_q    <= addr_dec(head_q);
			half_q    <= half_next;
			step_q    <= VW'(1);
			falling_q <= 1'b0;
		end else if (state_q == ST_CMP) begin
			if (cmp_rise) begin
				falling_q <= 1'b0;
			end else begin
				newer_q   <= $signed(rd_data);
				addr_q    <= addr_dec(addr_q);
				step_q    <= step_next;
				falling_q <= walk_last;
			end
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_data_q.coasting         <= coast_next;
			out_data_q.velocity_falling <= falling_q;
			out_data_q.accel_count      <= low16(accel_cnt_q);
			out_data_q.velocity_count   <= low16(vel_cnt_next);
			out_data_q.safety_count     <= low16(safety_cnt_next);
		end
	end

	assign report.valid = out_valid_q;
	assign report.data  = out_data_q;

endmodule

`default_nettype wire

FILE: hdl/cpd_checker.sv
`default_nettype none

module cpd_checker
	import cpd_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    in_valid,
	input wire logic    in_ready,
	input wire logic    out_valid,
	input wire logic    out_ready,
	input wire report_t out_data
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// an accepted sample closes the input in the cycle after it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accepting a sample");

	// a new result appears only from the busy phase of a sample
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result word appeared while the block was idle");

endmodule

bind coast_phase_detector_unit cpd_checker u_cpd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (sample.valid),
	.in_ready (sample.ready),
	.out_valid(report.valid),
	.out_ready(report.ready),
	.out_data (report.data)
);

`default_nettype wire

FILE: dv/coast_phase_detector_unit_tb.sv
module coast_phase_detector_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cpd_pkg::*;

	localparam int HIST_DEPTH    = 16;
	localparam int DRAIN_CYCLES  = 40;
	localparam int FLIGHT_ITEMS  = 255;
	localparam int FLIGHT_PHASES = 6;
	localparam int CEILING_ITEMS = 64;
	localparam longint CYCLE_LIMIT = 5_000_000;
	localparam int MAX_PRINTED   = 100;

	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic [15:0] COUNT_CEIL = '1;
	localparam logic [CFG_INDEX_W-1:0] REG_INDEX_TOP = '1;

	typedef enum {SEG_BOOST, SEG_COAST, SEG_NOISE} segment_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	cpd_chan_if #(.word_t(sample_t)) sample_ch ();
	cpd_chan_if #(.word_t(report_t)) report_ch ();

	coast_phase_detector_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample_ch),
		.report(report_ch)
	);

	// predictor copy of the block state and its registers
	logic signed [31:0] vel_hist [HIST_DEPTH];
	logic [3:0]         hist_head;
	logic [4:0]         hist_count;
	logic [15:0]        acc_run, vel_run, safe_run;
	logic signed [31:0] lim_accel;
	logic [30:0]        slack_vel;
	logic [15:0]        need_acc, need_vel, need_safe;

	report_t expected_reports [$];

	bit     send_idle;
	bit     recv_idle;
	int     hold_cycles;
	int     mismatches;
	int     samples_sent;
	int     reports_checked;
	int     coast_seen;
	int     falling_seen;
	longint cycle_count;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [15:0] bump(logic [15:0] c);
		return (c == COUNT_CEIL) ? c : c + 16'd1;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > S32_MAX)
			return S32_MAX;
		if (v < S32_MIN)
			return S32_MIN;
		return v[31:0];
	endfunction

	// advance the predictor by one sample word and return the report it causes
	function automatic report_t predict_report(sample_t w);
		report_t            r;
		logic signed [31:0] acc_s, vel_s;
		longint             newer, older, slack_l;
		int unsigned        newest, half, idx, i;
		bit                 falling, rise_seen, coast;
		acc_s = w.accel_vertical;
		vel_s = w.velocity_vertical;
		slack_l = longint'(slack_vel);
		falling = 1'b0;
		rise_seen = 1'b0;
		coast = 1'b0;

		// push the velocity into the history ring
		vel_hist[hist_head] = vel_s;
		newest = 32'(hist_head);
		hist_head = (hist_head == HIST_DEPTH - 1) ? 4'd0 : hist_head + 4'd1;
		if (hist_count < HIST_DEPTH)
			hist_count++;

		if (acc_s <= lim_accel)
			acc_run = bump(acc_run);
		else
			acc_run = (acc_run > 16'd2) ? acc_run - 16'd2 : 16'd0;

		// walk the newer half of the history, stop at the first excessive rise
		half = 32'(hist_count) / 2;
		newer = longint'(vel_s);
		for (i = 1; i < half && !rise_seen; i++) begin
			idx = (newest + HIST_DEPTH - i) % HIST_DEPTH;
			older = longint'(vel_hist[idx]);
			falling = 1'b1;
			if (newer > older + slack_l) begin
				falling = 1'b0;
				rise_seen = 1'b1;
			end
			newer = older;
		end

		if (falling)
			vel_run = bump(vel_run);
		else
			vel_run = (vel_run > 16'd1) ? vel_run - 16'd1 : 16'd0;

		if (acc_run >= need_acc || vel_run >= need_vel) begin
			safe_run = bump(safe_run);
			coast = (safe_run >= need_safe);
		end else begin
			safe_run = (safe_run > 16'd1) ? safe_run - 16'd1 : 16'd0;
		end

		r.coasting = coast;
		r.velocity_falling = falling;
		r.accel_count = acc_run;
		r.velocity_count = vel_run;
		r.safety_count = safe_run;
		return r;
	endfunction

	function automatic bit field_ok(string name, longint unsigned want_v, longint unsigned got_v);
		if (want_v != got_v && mismatches < MAX_PRINTED)
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
		return want_v == got_v;
	endfunction

	// write one register and mirror it in the predictor
	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ACCEL_LIMIT:         lim_accel = val;
			REG_VELOCITY_SLACK:      slack_vel = val[30:0];
			REG_ACCEL_COUNT_NEEDED:  need_acc = val[15:0];
			REG_VEL_COUNT_NEEDED:    need_vel = val[15:0];
			REG_SAFETY_COUNT_NEEDED: need_safe = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one sample word after a drawn gap and hold it until accepted
	task automatic send_sample(input logic signed [31:0] acc, input logic signed [31:0] vel);
		int      gap;
		sample_t w;
		gap = send_idle ? $urandom_range(0, 8) : 0;
		w.accel_vertical = acc;
		w.velocity_vertical = vel;
		@(negedge clk);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data <= w;
		do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
		expected_reports.push_back(predict_report(w));
		samples_sent++;
	endtask

	// drop valid and wait until every pending report has come out
	task automatic drain_reports();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] limit, input logic [31:0] slack,
			input logic [31:0] n_acc, input logic [31:0] n_vel, input logic [31:0] n_safe);
		drain_reports();
		write_register(REG_ACCEL_LIMIT, limit);
		write_register(REG_VELOCITY_SLACK, slack);
		write_register(REG_ACCEL_COUNT_NEEDED, n_acc);
		write_register(REG_VEL_COUNT_NEEDED, n_vel);
		write_register(REG_SAFETY_COUNT_NEEDED, n_safe);
	endtask

	function automatic logic [31:0] pick_threshold();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return {16'($urandom_range(0, 16'hFFFF)), 16'hFFFF};
			2, 3: return $urandom_range(1, 4);
			default: return $urandom_range(1, 24);
		endcase
	endfunction

	task automatic configure_random();
		logic [31:0] limit, slack;
		case ($urandom_range(0, 5))
			0: limit = S32_MIN;
			1: limit = S32_MAX;
			2: limit = $urandom;
			default: limit = -$urandom_range(0, 20 * 65536);
		endcase
		case ($urandom_range(0, 5))
			0: slack = {1'($urandom_range(0, 1)), 31'd0};
			1: slack = {1'($urandom_range(0, 1)), 31'h7FFF_FFFF};
			2: slack = $urandom;
			default: slack = $urandom_range(0, 65536);
		endcase
		configure(limit, slack, pick_threshold(), pick_threshold(), pick_threshold());
	endtask

	// fill the history from empty, equal and rising velocities, field extremes
	task automatic test_short_history();
		send_sample(ACCEL_LIMIT_RST, 32'sd1000);
		send_sample(ACCEL_LIMIT_RST, 32'sd900);
		send_sample(ACCEL_LIMIT_RST, 32'sd800);
		send_sample(ACCEL_LIMIT_RST + 32'sd1, 32'sd800);
		send_sample(S32_MIN, 32'sd801);
		send_sample(S32_MAX, S32_MAX);
		send_sample(S32_MIN, S32_MIN);
		send_sample(32'sd0, S32_MIN);
	endtask

	// zero thresholds, full-scale limit and slack, masked upper bits, unused indexes
	task automatic test_register_extremes();
		int k;
		configure(S32_MAX, 32'hFFFF_FFFF, 32'h5A5A_0000, 32'hABCD_0003, 32'd0);
		for (k = REG_SAFETY_COUNT_NEEDED + 1; k <= REG_INDEX_TOP; k++)
			write_register(CFG_INDEX_W'(k), 32'hFFFF_FFFF);
		send_sample(S32_MIN, S32_MIN);
		send_sample(S32_MIN, S32_MAX);
		send_sample(S32_MAX, S32_MIN);
		send_sample(32'sd0, S32_MAX);

		// let the safety counter rise to its threshold, then fall away
		configure(S32_MIN, 32'd0, 32'd3, 32'd65535, 32'd2);
		repeat (4) send_sample(S32_MIN, 32'sd100);
		repeat (8) send_sample(32'sd0, 32'sd100);
	endtask

	// flight-like segments: boost, coast with small bumps, and raw noise
	task automatic run_flight(int n_items);
		int       sent, seg_len, k;
		segment_t kind;
		longint   acc, vel;
		sent = 0;
		vel = longint'($urandom_range(0, 1 << 24));
		while (sent < n_items) begin
			k = $urandom_range(0, 9);
			kind = (k < 2) ? SEG_BOOST : (k < 8) ? SEG_COAST : SEG_NOISE;
			seg_len = $urandom_range(3, 40);
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			for (k = 0; k < seg_len && sent < n_items; k++) begin
				case (kind)
					SEG_BOOST: begin
						acc = longint'(lim_accel) + longint'($urandom_range(1, 200000));
						vel = vel + longint'($urandom_range(0, 50000));
					end
					SEG_COAST: begin
						acc = longint'(lim_accel) - longint'($urandom_range(0, 200000));
						vel = vel - longint'($urandom_range(0, 20000));
						if ($urandom_range(0, 4) == 0)
							vel = vel + longint'($urandom_range(0, 70000));
					end
					default: begin
						acc = longint'($signed($urandom));
						vel = longint'($signed($urandom));
					end
				endcase
				vel = clamp32(vel);
				send_sample(clamp32(acc), clamp32(vel));
				sent++;
			end
		end
	endtask

	task automatic test_random_flights();
		int phase;
		for (phase = 0; phase < FLIGHT_PHASES; phase++) begin
			case (phase)
				0: configure(ACCEL_LIMIT_RST, 32'(VELOCITY_SLACK_RST), 32'(ACCEL_NEEDED_RST),
						32'(VEL_NEEDED_RST), 32'(SAFETY_NEEDED_RST));
				1: configure(S32_MIN, 32'h7FFF_FFFF, 32'd65535, 32'd65535, 32'd65535);
				2: configure(S32_MAX, 32'd0, 32'd0, 32'd0, 32'd0);
				default: configure_random();
			endcase
			run_flight(FLIGHT_ITEMS);
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	// hold off the report side for a long stretch while samples keep coming
	task automatic test_output_backpressure();
		drain_reports();
		send_idle = 1'b0;
		hold_cycles = 200;
		repeat (12) send_sample($urandom, $urandom);
		drain_reports();
		send_idle = 1'b1;
	endtask

	// pause the sample side until everything is out, then resume
	task automatic test_sender_pause();
		repeat (2) begin
			repeat (6) send_sample($urandom, $urandom);
			drain_reports();
		end
	endtask

	// climb the acceleration and safety counters on a long run, then drop them back
	task automatic test_counter_ceiling();
		int k;
		configure(S32_MAX, 32'd0, 32'd1, 32'd65535, 32'd65535);
		send_idle = 1'b0;
		recv_idle = 1'b0;
		for (k = 0; k < CEILING_ITEMS; k++)
			send_sample($urandom, k);
		configure(S32_MIN, 32'd0, 32'd65535, 32'd65535, 32'd65535);
		repeat (4) send_sample(S32_MAX, 32'sd0);
	endtask

	// report side: draw a stall per word, or take a requested long hold
	initial begin : report_sink
		int stall;
		report_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = recv_idle ? $urandom_range(0, 8) : 0;
			end
			if (stall > 0) begin
				report_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			report_ch.ready <= 1'b1;
			do @(posedge clk); while (!(report_ch.valid && report_ch.ready));
		end
	end

	// compare each accepted report word with the oldest pending prediction
	always @(posedge clk) begin : check_reports
		report_t want, got;
		bit      good;
		if (arst_n && report_ch.valid && report_ch.ready) begin
			got = report_ch.data;
			if (expected_reports.size() == 0) begin
				if (mismatches < MAX_PRINTED)
					$display("%0t ns: report word with no sample pending, expected none, actual %h",
						$time, got);
				mismatches++;
			end else begin
				want = expected_reports.pop_front();
				good = 1'b1;
				good &= field_ok("coasting", want.coasting, got.coasting);
				good &= field_ok("velocity_falling", want.velocity_falling,
					got.velocity_falling);
				good &= field_ok("accel_count", want.accel_count, got.accel_count);
				good &= field_ok("velocity_count", want.velocity_count, got.velocity_count);
				good &= field_ok("safety_count", want.safety_count, got.safety_count);
				if (!good)
					mismatches++;
				reports_checked++;
				coast_seen += got.coasting;
				falling_seen += got.velocity_falling;
			end
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t ns: run exceeded %0d cycles, %0d reports pending", $time,
				CYCLE_LIMIT, expected_reports.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		hold_cycles = 0;
		mismatches = 0;
		samples_sent = 0;
		reports_checked = 0;
		coast_seen = 0;
		falling_seen = 0;
		cycle_count = 0;

		hist_head = '0;
		hist_count = '0;
		acc_run = '0;
		vel_run = '0;
		safe_run = '0;
		lim_accel = ACCEL_LIMIT_RST;
		slack_vel = VELOCITY_SLACK_RST;
		need_acc = ACCEL_NEEDED_RST;
		need_vel = VEL_NEEDED_RST;
		need_safe = SAFETY_NEEDED_RST;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_short_history();
		test_register_extremes();
		test_random_flights();
		test_output_backpressure();
		test_sender_pause();
		test_counter_ceiling();
		drain_reports();

		$display("Checked %0d report words from %0d samples: %0d coasting, %0d velocity falling.",
			reports_checked, samples_sent, coast_seen, falling_seen);
		$display("Swept limits, slack and thresholds to both ends, ran long counter climbs, %s",
			"stalled both sides.");
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: coast_phase_detector_unit.f
hdl/cpd_pkg.sv
hdl/cpd_chan_if.sv
hdl/cpd_history.sv
hdl/coast_phase_detector_unit.sv
hdl/cpd_checker.sv
dv/coast_phase_detector_unit_tb.sv
